/* design/vphg_pkg.sv */
// ----------------------------------------------------------------------------
// vphg_pkg
// Shared types and constants for the volts-per-hertz reference generator.
// ----------------------------------------------------------------------------
`default_nettype none

package vphg_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 31;

  localparam logic [CfgIdxW-1:0] CFG_SPEED_STEP    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PHASE_GAIN    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_BOOST_VOLTAGE = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_VOLTAGE_SLOPE = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ANGLE_OFFSET  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_START_ANGLE   = 3'd5;

  // Q15 slope product is scaled back by this many bits
  localparam int SlopeShift = 15;

  typedef struct packed {
    logic signed [15:0] speed_target;
    logic               restart;
  } vphg_in_t;

  typedef struct packed {
    logic        [15:0] angle;
    logic signed [15:0] magnitude;
    logic signed [15:0] working_speed;
  } vphg_out_t;

  typedef struct packed {
    logic        [30:0] speed_step;
    logic        [15:0] phase_gain;
    logic signed [15:0] boost_voltage;
    logic signed [16:0] voltage_slope;
    logic        [15:0] angle_offset;
    logic        [15:0] start_angle;
  } vphg_cfg_t;

endpackage

`default_nettype wire

/* design/vphg_ramp.sv */
// ----------------------------------------------------------------------------
// vphg_ramp
// Speed slew: moves the Q15.16 accumulator toward the target by the step,
// clamped at the target. Hands the new integer speed to the result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module vphg_ramp
  import vphg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire vphg_in_t           req,
  input  wire logic [30:0]        speed_step,
  output logic signed [15:0]      speed_w,
  output logic                    restart
);

  logic signed [31:0] acc_r;
  logic signed [31:0] acc_nxt;

  logic signed [33:0] base;
  logic signed [33:0] tgt;
  logic signed [33:0] step;
  logic signed [33:0] up;
  logic signed [33:0] dn;
  logic signed [33:0] res;

  always_comb begin
    base = req.restart ? 34'sd0 : {{2{acc_r[31]}}, acc_r};
    tgt  = {{2{req.speed_target[15]}}, req.speed_target, 16'b0};
    step = $signed({3'b0, speed_step});
    up   = base + step;
    dn   = base - step;
    if (base < tgt) begin
      res = (up > tgt) ? tgt : up;
    end else if (base > tgt) begin
      res = (dn < tgt) ? tgt : dn;
    end else begin
      res = base;
    end
    acc_nxt = res[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (load) begin
      acc_r <= acc_nxt;
    end
  end

  assign speed_w = acc_nxt[31:16];
  assign restart = req.restart;

endmodule

`default_nettype wire

/* design/vphg_synth.sv */
// ----------------------------------------------------------------------------
// vphg_synth
// Phase integration and V/f magnitude; holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module vphg_synth
  import vphg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire logic signed [15:0] speed_w,
  input  wire logic               restart,
  input  wire vphg_cfg_t          cfg,
  output vphg_out_t               result
);

  logic        [31:0] phase_r;
  logic        [31:0] phase_nxt;
  logic        [31:0] phase_base;
  logic signed [32:0] dphase;
  logic        [16:0] wabs;
  logic signed [34:0] vprod;
  logic signed [15:0] mag;
  vphg_out_t          result_r;
  vphg_out_t          result_nxt;

  always_comb begin
    dphase     = $signed({{17{speed_w[15]}}, speed_w}) * $signed({17'b0, cfg.phase_gain});
    phase_base = restart ? {cfg.start_angle, 16'b0} : phase_r;
    phase_nxt  = phase_base + dphase[31:0];

    // |speed| never exceeds one per-unit (32768), so no clamp is needed
    wabs  = speed_w[15] ? (17'd0 - {1'b1, speed_w}) : {1'b0, speed_w};
    vprod = $signed({{18{cfg.voltage_slope[16]}}, cfg.voltage_slope})
          * $signed({18'b0, wabs});
    mag   = cfg.boost_voltage + vprod[SlopeShift+15:SlopeShift];

    result_nxt.angle         = phase_nxt[31:16] + cfg.angle_offset;
    result_nxt.magnitude     = mag;
    result_nxt.working_speed = speed_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (load) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result_nxt;
    end
  end

  assign result = result_r;

endmodule

`default_nettype wire

/* design/volts_per_hertz_generator.sv */
// ----------------------------------------------------------------------------
// volts_per_hertz_generator
// Open-loop V/f reference: ramps speed, integrates phase, scales voltage.
//
// Input channel in_valid/in_stall/in_data carries one request per control
// period: a Q15 speed target and a restart flag. Output channel
// out_valid/out_stall/out_data returns one result per request: angle,
// magnitude and working speed. Requests are accepted when in_valid is high
// and in_stall is low; results are taken likewise on the output side.
// Two register stages: the input register and the result register, with the
// speed ramp, phase and magnitude computed in one pass between them.
// Requests pass the input register, then the result register, to out_valid;
// one request per cycle is sustained while out_stall is low.
// When out_stall is held, both stages fill and in_stall rises; results
// stay stable until taken. Reset clears the pipeline, the cfg_ registers, the
// speed accumulator and the phase. Write the cfg_ registers only while idle;
// start_angle takes effect at the next restart request.
// ----------------------------------------------------------------------------
`default_nettype none

module volts_per_hertz_generator
  import vphg_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire vphg_in_t            in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output vphg_out_t                out_data,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_wdata
);

  vphg_cfg_t          cfg_r;
  vphg_in_t           req_r;
  logic               v1_r;
  logic               v2_r;
  logic               adv2;
  logic               in_take;
  logic signed [15:0] speed_w;
  logic               restart;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SPEED_STEP:    cfg_r.speed_step    <= cfg_wdata[30:0];
        CFG_PHASE_GAIN:    cfg_r.phase_gain    <= cfg_wdata[15:0];
        CFG_BOOST_VOLTAGE: cfg_r.boost_voltage <= cfg_wdata[15:0];
        CFG_VOLTAGE_SLOPE: cfg_r.voltage_slope <= cfg_wdata[16:0];
        CFG_ANGLE_OFFSET:  cfg_r.angle_offset  <= cfg_wdata[15:0];
        CFG_START_ANGLE:   cfg_r.start_angle   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign adv2     = v1_r && (!v2_r || !out_stall);
  assign in_stall = v1_r && !adv2;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_take || (v1_r && !adv2);
      v2_r <= adv2 || (v2_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r <= in_data;
    end
  end

  vphg_ramp u_ramp (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (adv2),
    .req        (req_r),
    .speed_step (cfg_r.speed_step),
    .speed_w    (speed_w),
    .restart    (restart)
  );

  vphg_synth u_synth (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (adv2),
    .speed_w (speed_w),
    .restart (restart),
    .cfg     (cfg_r),
    .result  (out_data)
  );

  assign out_valid = v2_r;

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the volts-per-hertz reference generator.
//
// A queue of speed-target requests feeds a clocked driver, and a clocked
// monitor takes the results. Both sides idle and stall at random. Each
// accepted request runs through a local model of the speed ramp, the phase
// integrator and the magnitude scaling, and every result is compared field
// by field in order. Registers change only while the block is idle. A short
// directed part hits the extreme settings, the slew clamp, a zero slew step,
// the delayed start angle and negative rounding. Random phases follow, each
// with fresh settings and mostly held targets so that the ramp settles.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import vphg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 500000;
  localparam int MaxIdle    = 18;
  localparam int DrainWait  = 10;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  vphg_in_t            in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  vphg_out_t           out_data;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  // register shadow
  logic        [30:0] speed_step    = '0;
  logic        [15:0] phase_gain    = '0;
  logic signed [15:0] boost_voltage = '0;
  logic signed [16:0] voltage_slope = '0;
  logic        [15:0] angle_offset  = '0;
  logic        [15:0] start_angle   = '0;

  // ramp and phase state
  logic signed [31:0] speed_acc = '0;
  logic        [31:0] phase_acc = '0;

  vphg_in_t  pending_reqs[$];
  vphg_out_t due_results[$];

  int n_errors    = 0;
  int cycle_count = 0;
  int in_wait     = 0;
  int out_wait    = 0;
  bit in_spread   = 1'b1;
  bit out_spread  = 1'b1;

  volts_per_hertz_generator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic vphg_out_t advance_vf(input vphg_in_t req);
    logic signed [15:0] tgt16;
    longint target, acc, w, wabs, mag;
    vphg_out_t res;
    tgt16 = req.speed_target;
    target = longint'(tgt16) * 65536;
    if (req.restart) begin
      speed_acc = '0;
      phase_acc = {start_angle, 16'h0000};
    end
    acc = longint'(speed_acc);
    if (acc < target) begin
      acc = acc + longint'(speed_step);
      if (acc > target) acc = target;
    end else if (acc > target) begin
      acc = acc - longint'(speed_step);
      if (acc < target) acc = target;
    end
    speed_acc = 32'(acc);
    w = acc >>> 16;
    phase_acc = phase_acc + 32'(w * longint'(phase_gain));
    wabs = (w < 0) ? -w : w;
    if (wabs > 32768) wabs = 32768;
    mag = longint'(boost_voltage) + ((longint'(voltage_slope) * wabs) >>> SlopeShift);
    res.angle = phase_acc[31:16] + angle_offset;
    res.magnitude = 16'(mag);
    res.working_speed = 16'(w);
    return res;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    n_errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_wait <= 0;
    end else begin
      if (in_valid && !in_stall) due_results.push_back(advance_vf(in_data));
      if (!in_valid || !in_stall) begin
        if (in_wait > 0) begin
          in_valid <= 1'b0;
          in_wait <= in_wait - 1;
        end else if (pending_reqs.size() > 0) begin
          in_data <= pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_wait <= in_spread ? $urandom_range(0, MaxIdle) : 0;
          if ($urandom_range(0, 39) == 0) in_spread <= !in_spread;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    vphg_out_t want;
    int n;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_wait <= 0;
    end else if (out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result %p", out_data));
      end else begin
        want = due_results.pop_front();
        if (out_data.angle !== want.angle)
          flag_mismatch($sformatf("angle %0d, expected %0d", out_data.angle, want.angle));
        if (out_data.magnitude !== want.magnitude)
          flag_mismatch($sformatf("magnitude %0d, expected %0d",
                                  out_data.magnitude, want.magnitude));
        if (out_data.working_speed !== want.working_speed)
          flag_mismatch($sformatf("working_speed %0d, expected %0d",
                                  out_data.working_speed, want.working_speed));
      end
      n = out_spread ? $urandom_range(0, MaxIdle) : 0;
      out_wait <= n;
      out_stall <= (n != 0);
      if ($urandom_range(0, 39) == 0) out_spread <= !out_spread;
    end else if (out_wait > 0) begin
      out_wait <= out_wait - 1;
      out_stall <= (out_wait > 1);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int value);
    logic [31:0] v;
    v = value;
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v[30:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SPEED_STEP:    speed_step = v[30:0];
      CFG_PHASE_GAIN:    phase_gain = v[15:0];
      CFG_BOOST_VOLTAGE: boost_voltage = v[15:0];
      CFG_VOLTAGE_SLOPE: voltage_slope = v[16:0];
      CFG_ANGLE_OFFSET:  angle_offset = v[15:0];
      CFG_START_ANGLE:   start_angle = v[15:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input int step, input int gain, input int boost,
                           input int slope, input int offset, input int start);
    write_reg(CFG_SPEED_STEP, step);
    write_reg(CFG_PHASE_GAIN, gain);
    write_reg(CFG_BOOST_VOLTAGE, boost);
    write_reg(CFG_VOLTAGE_SLOPE, slope);
    write_reg(CFG_ANGLE_OFFSET, offset);
    write_reg(CFG_START_ANGLE, start);
  endtask

  task automatic push_req(input int target, input bit restart);
    vphg_in_t r;
    r.speed_target = 16'(target);
    r.restart = restart;
    pending_reqs.push_back(r);
  endtask

  // sender holds off until every result is back, then the pipe drains
  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_valid || due_results.size() != 0)
      @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  function automatic int pick_target();
    case ($urandom_range(0, 7))
      0: return 32767;
      1: return -32768;
      2: return 0;
      3: return int'($urandom_range(0, 600)) - 300;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  function automatic int pick_step();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 1 << 30;
      2: return $urandom_range(1, 1 << 16);
      3: return $urandom_range(1 << 24, 1 << 30);
      default: return $urandom_range(1 << 16, 1 << 24);
    endcase
  endfunction

  function automatic int pick_u16();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 65535;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic random_settings();
    int boost, slope;
    boost = int'($urandom_range(0, 65535)) - 32768;
    slope = int'($urandom_range(0, 131070)) - 65535;
    if ($urandom_range(0, 5) == 0) boost = $urandom_range(0, 1) ? 32767 : -32768;
    if ($urandom_range(0, 5) == 0) slope = $urandom_range(0, 1) ? 65535 : -65535;
    write_all(pick_step(), pick_u16(), boost, slope, pick_u16(), pick_u16());
  endtask

  // held targets let the ramp settle; some segments are pure noise
  task automatic random_requests(input int n_items);
    int left, seg, tgt;
    bit noisy;
    left = n_items;
    while (left > 0) begin
      noisy = ($urandom_range(0, 7) == 0);
      tgt = pick_target();
      seg = $urandom_range(1, 40);
      if (seg > left) seg = left;
      for (int i = 0; i < seg; i++) begin
        if (noisy) tgt = pick_target();
        push_req(tgt, $urandom_range(0, 31) == 0);
      end
      left -= seg;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // full slew, maximum gains; new start angle waits for a restart
    write_all(1 << 30, 65535, 32767, 65535, 65535, 49152);
    push_req(32767, 1'b0);
    push_req(32767, 1'b0);
    push_req(-32768, 1'b0);
    push_req(-32768, 1'b0);
    push_req(-32768, 1'b0);
    push_req(0, 1'b1);
    push_req(32767, 1'b1);
    push_req(-1, 1'b0);
    push_req(1, 1'b0);
    wait_idle();

    // zero slew: speed holds
    write_all(0, 1, -32768, -65535, 0, 0);
    push_req(32767, 1'b0);
    push_req(-32768, 1'b0);
    push_req(100, 1'b1);
    push_req(0, 1'b0);
    wait_idle();

    // fractional step into negative speed
    write_all(3 << 15, 65535, 0, -1, 12345, 65535);
    push_req(-5, 1'b1);
    push_req(-5, 1'b0);
    push_req(-5, 1'b0);
    push_req(-5, 1'b0);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      random_settings();
      random_requests(230);
      wait_idle();
    end

    if (n_errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
